// ===== rtl/gbi_pkg.sv =====
// Shared types, codes and constants of the grid bilinear interpolator.
package gbi_pkg;

  localparam int MAX_AXIS_POINTS_DEF = 64;
  localparam int GRID_CELLS_DEF      = 4096;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 32;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int Q_FRAC   = 16;
  localparam int DIFF_W   = VAL_W + 1;
  localparam int DIVD_W   = DIFF_W + Q_FRAC;
  localparam int RATIO_W  = 31;
  localparam int RMAG_W   = 30;
  localparam logic [RMAG_W-1:0] RATIO_LIMIT = RMAG_W'(30'h2000_0000);

  localparam logic [CMD_W-1:0] CMD_WR_X = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_Y = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_Z = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EVAL = 2'd3;

  localparam logic [MODE_W-1:0] MODE_UNKNOWN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONST    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NEAREST  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BILINEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XCOUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YCOUNT = 2'd2;

  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_ACCEPT    = 4'd1;
  localparam logic [3:0] OP_SCAN      = 4'd2;
  localparam logic [3:0] OP_FIX       = 4'd3;
  localparam logic [3:0] OP_RD_LO     = 4'd4;
  localparam logic [3:0] OP_RD_HI     = 4'd5;
  localparam logic [3:0] OP_CAP_HI    = 4'd6;
  localparam logic [3:0] OP_NEAR_ADJ  = 4'd7;
  localparam logic [3:0] OP_DIV_START = 4'd8;
  localparam logic [3:0] OP_DIV_STORE = 4'd9;
  localparam logic [3:0] OP_GADDR     = 4'd10;
  localparam logic [3:0] OP_GCAP      = 4'd11;
  localparam logic [3:0] OP_LPREP     = 4'd12;
  localparam logic [3:0] OP_MUL_LO    = 4'd13;
  localparam logic [3:0] OP_MUL_HI    = 4'd14;
  localparam logic [3:0] OP_LFIN      = 4'd15;
  localparam logic [3:0] OP_EMIT      = 4'd0;

  typedef struct packed {
    logic [3:0] op;
    logic       emit;
    logic [1:0] sel;
  } gbi_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              scan_done;
    logic              div_done;
    logic              out_busy;
  } gbi_stat_t;

endpackage

// ===== rtl/gbi_datapath.sv =====
// Datapath: axis and grid memories, axis scan, ratio divider, line multiplier, output word.
module gbi_datapath #(
  parameter int MAX_AXIS_POINTS = gbi_pkg::MAX_AXIS_POINTS_DEF,
  parameter int GRID_CELLS      = gbi_pkg::GRID_CELLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gbi_pkg::gbi_cmd_t                    cmd,
  output gbi_pkg::gbi_stat_t                   stat,
  input  logic [gbi_pkg::CMD_W-1:0]            in_cmd,
  input  logic [gbi_pkg::IDX_W-1:0]            in_entry_index,
  input  logic signed [gbi_pkg::VAL_W-1:0]     in_entry_value,
  input  logic signed [gbi_pkg::VAL_W-1:0]     in_query_x,
  input  logic signed [gbi_pkg::VAL_W-1:0]     in_query_y,
  input  logic                                 cfg_wr_en,
  input  logic [gbi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gbi_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gbi_pkg::VAL_W-1:0]     out_z_value,
  output logic                                 out_mode_error
);
  import gbi_pkg::*;

  localparam int AW = (MAX_AXIS_POINTS > 1) ? $clog2(MAX_AXIS_POINTS) : 1;
  localparam int CW = $clog2(MAX_AXIS_POINTS + 1);
  localparam int GW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int IW = CW + AW + 1;
  localparam int PW = RMAG_W + DIFF_W;

  logic [MODE_W-1:0]  mode_r;
  logic [COUNT_W-1:0] xcnt_r, ycnt_r;
  logic [CW-1:0]      nx, ny, maxn;

  logic signed [VAL_W-1:0] xmem [MAX_AXIS_POINTS];
  logic signed [VAL_W-1:0] ymem [MAX_AXIS_POINTS];
  logic signed [VAL_W-1:0] zmem [GRID_CELLS];
  logic signed [VAL_W-1:0] x_rdata_r, y_rdata_r, g_rdata_r;
  logic [AW-1:0]           x_raddr, y_raddr;
  logic [31:0]             wr_idx_ext, g_addr_ext;
  logic [IW-1:0]           g_addr_r;
  logic                    g_oob_r;

  logic signed [VAL_W-1:0] qx_r, qy_r;
  logic [CW-1:0]           scan_i_r, rd_i_r, xpos_r, ypos_r;
  logic                    rd_v_r, xstop_r, ystop_r, xlt0_r, ylt0_r, xgel_r, ygel_r;
  logic [AW-1:0]           px_r, py_r;
  logic signed [VAL_W-1:0] xlo_r, xhi_r, ylo_r, yhi_r;

  logic signed [DIFF_W-1:0] d_num, d_den;
  logic signed [VAL_W-1:0]  sel_hi, sel_lo, sel_q;
  logic [DIFF_W-1:0]        rem_r, den_r;
  logic [DIVD_W-1:0]        dq_r;
  logic [5:0]               dcnt_r;
  logic                     dsign_r, dzero_r;
  logic [DIFF_W:0]          r2;
  logic                     ge;
  logic [RMAG_W-1:0]        qmag;
  logic signed [RATIO_W-1:0] fx_r, fy_r, rat;

  logic signed [VAL_W-1:0]  z0_r, z1_r, z2_r, z3_r, zmin_r, zmax_r, zres_r, gval;
  logic signed [VAL_W-1:0]  lhi_r, lhi, llo;
  logic signed [RATIO_W-1:0] lf;
  logic signed [DIFF_W-1:0] ld;
  logic [DIFF_W-1:0]        ld_mag_r;
  logic [RMAG_W-1:0]        lf_mag_r;
  logic                     lneg_r;
  logic [1:0]               lsel_r;
  logic [PW-1:0]            acc_r, pp_r, psum;
  logic [PW-Q_FRAC-1:0]     tmag;
  logic signed [PW-Q_FRAC+1:0] lres;
  logic signed [VAL_W-1:0]  lsat;

  logic                     out_valid_r, out_err_r;
  logic signed [VAL_W-1:0]  out_z_r;

  function automatic logic [AW-1:0] pick_pos(input logic [CW-1:0] cnt, input logic [CW-1:0] n,
                                             input logic lt0, input logic gel,
                                             input logic [MODE_W-1:0] md);
    logic [AW-1:0] p;
    if (cnt == '0) p = '0;
    else if (cnt >= n) p = AW'(n - CW'(2));
    else p = AW'(cnt - CW'(1));
    if (md == MODE_CONST) p = '0;
    else if (md == MODE_BILINEAR) begin
      if (lt0) p = '0;
      else if (gel) p = AW'(n - CW'(2));
    end
    return p;
  endfunction

  always_comb begin
    if (xcnt_r < COUNT_W'(2)) nx = CW'(2);
    else if (int'(xcnt_r) > MAX_AXIS_POINTS) nx = CW'(MAX_AXIS_POINTS);
    else nx = CW'(xcnt_r);
    if (ycnt_r < COUNT_W'(2)) ny = CW'(2);
    else if (int'(ycnt_r) > MAX_AXIS_POINTS) ny = CW'(MAX_AXIS_POINTS);
    else ny = CW'(ycnt_r);
    maxn = (nx > ny) ? nx : ny;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UNKNOWN;
      xcnt_r <= COUNT_W'(2);
      ycnt_r <= COUNT_W'(2);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MODE:   mode_r <= cfg_data[MODE_W-1:0];
        CFG_XCOUNT: xcnt_r <= cfg_data[COUNT_W-1:0];
        CFG_YCOUNT: ycnt_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign wr_idx_ext = 32'(in_entry_index);
  assign g_addr_ext = 32'(g_addr_r);

  always_comb begin
    case (cmd.op)
      OP_SCAN: begin
        x_raddr = scan_i_r[AW-1:0];
        y_raddr = scan_i_r[AW-1:0];
      end
      OP_RD_HI: begin
        x_raddr = px_r + AW'(1);
        y_raddr = py_r + AW'(1);
      end
      default: begin
        x_raddr = px_r;
        y_raddr = py_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT && !cmd.emit) begin
      if (in_cmd == CMD_WR_X && int'(in_entry_index) < MAX_AXIS_POINTS)
        xmem[wr_idx_ext[AW-1:0]] <= in_entry_value;
      if (in_cmd == CMD_WR_Y && int'(in_entry_index) < MAX_AXIS_POINTS)
        ymem[wr_idx_ext[AW-1:0]] <= in_entry_value;
      if (in_cmd == CMD_WR_Z && int'(in_entry_index) < GRID_CELLS)
        zmem[wr_idx_ext[GW-1:0]] <= in_entry_value;
    end
    x_rdata_r <= xmem[x_raddr];
    y_rdata_r <= ymem[y_raddr];
    g_rdata_r <= zmem[g_addr_ext[GW-1:0]];
    g_oob_r   <= (g_addr_ext >= 32'(GRID_CELLS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_i_r <= '0;
      rd_v_r   <= 1'b0;
    end else begin
      rd_v_r <= (cmd.op == OP_SCAN) && !cmd.emit;
      if (cmd.op == OP_ACCEPT && !cmd.emit) scan_i_r <= '0;
      else if (cmd.op == OP_SCAN && !cmd.emit) scan_i_r <= scan_i_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_i_r <= scan_i_r;
    if (cmd.op == OP_ACCEPT && !cmd.emit) begin
      qx_r    <= in_query_x;
      qy_r    <= in_query_y;
      xpos_r  <= '0;
      ypos_r  <= '0;
      xstop_r <= 1'b0;
      ystop_r <= 1'b0;
    end else if (rd_v_r) begin
      if (rd_i_r < nx && !xstop_r) begin
        if (x_rdata_r > qx_r) xstop_r <= 1'b1;
        else xpos_r <= rd_i_r + CW'(1);
      end
      if (rd_i_r < ny && !ystop_r) begin
        if (y_rdata_r > qy_r) ystop_r <= 1'b1;
        else ypos_r <= rd_i_r + CW'(1);
      end
      if (rd_i_r == '0) begin
        xlt0_r <= qx_r < x_rdata_r;
        ylt0_r <= qy_r < y_rdata_r;
      end
      if (rd_i_r == nx - CW'(1)) xgel_r <= qx_r >= x_rdata_r;
      if (rd_i_r == ny - CW'(1)) ygel_r <= qy_r >= y_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd.emit) begin
      case (cmd.op)
        OP_FIX: begin
          px_r <= pick_pos(xpos_r, nx, xlt0_r, xgel_r, mode_r);
          py_r <= pick_pos(ypos_r, ny, ylt0_r, ygel_r, mode_r);
        end
        OP_RD_HI: begin
          xlo_r <= x_rdata_r;
          ylo_r <= y_rdata_r;
        end
        OP_CAP_HI: begin
          xhi_r <= x_rdata_r;
          yhi_r <= y_rdata_r;
        end
        OP_NEAR_ADJ: begin
          if ($signed({qx_r, 1'b0}) > ($signed({xlo_r[VAL_W-1], xlo_r}) +
                                       $signed({xhi_r[VAL_W-1], xhi_r})))
            px_r <= px_r + AW'(1);
          if ($signed({qy_r, 1'b0}) > ($signed({ylo_r[VAL_W-1], ylo_r}) +
                                       $signed({yhi_r[VAL_W-1], yhi_r})))
            py_r <= py_r + AW'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sel_hi = cmd.sel[0] ? yhi_r : xhi_r;
    sel_lo = cmd.sel[0] ? ylo_r : xlo_r;
    sel_q  = cmd.sel[0] ? qy_r : qx_r;
    d_num  = $signed({sel_hi[VAL_W-1], sel_hi}) - $signed({sel_q[VAL_W-1], sel_q});
    d_den  = $signed({sel_hi[VAL_W-1], sel_hi}) - $signed({sel_lo[VAL_W-1], sel_lo});
    r2     = {rem_r, dq_r[DIVD_W-1]};
    ge     = r2 >= {1'b0, den_r};
    qmag   = (dq_r > DIVD_W'(RATIO_LIMIT)) ? RATIO_LIMIT : dq_r[RMAG_W-1:0];
    if (dzero_r) rat = '0;
    else if (dsign_r) rat = -$signed({1'b0, qmag});
    else rat = $signed({1'b0, qmag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.op == OP_DIV_START && !cmd.emit) begin
      dcnt_r <= 6'(DIVD_W);
    end else if (dcnt_r != '0) begin
      dcnt_r <= dcnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV_START && !cmd.emit) begin
      dq_r    <= {(d_num[DIFF_W-1] ? DIFF_W'(-d_num) : DIFF_W'(d_num)), {Q_FRAC{1'b0}}};
      den_r   <= d_den[DIFF_W-1] ? DIFF_W'(-d_den) : DIFF_W'(d_den);
      rem_r   <= '0;
      dsign_r <= d_num[DIFF_W-1] ^ d_den[DIFF_W-1];
      dzero_r <= (d_den == '0);
    end else if (dcnt_r != '0) begin
      dq_r  <= {dq_r[DIVD_W-2:0], ge};
      rem_r <= ge ? DIFF_W'(r2 - {1'b0, den_r}) : DIFF_W'(r2);
    end
    if (cmd.op == OP_DIV_STORE && !cmd.emit) begin
      if (cmd.sel[0]) fy_r <= rat;
      else fx_r <= rat;
    end
  end

  assign gval = g_oob_r ? '0 : g_rdata_r;

  always_comb begin
    case (cmd.sel)
      2'd0: begin
        lhi = z1_r;
        llo = z0_r;
        lf  = fx_r;
      end
      2'd1: begin
        lhi = z3_r;
        llo = z2_r;
        lf  = fx_r;
      end
      default: begin
        lhi = zmax_r;
        llo = zmin_r;
        lf  = fy_r;
      end
    endcase
    ld   = $signed({lhi[VAL_W-1], lhi}) - $signed({llo[VAL_W-1], llo});
    psum = acc_r + {pp_r[PW-Q_FRAC-1:0], {Q_FRAC{1'b0}}};
    tmag = psum[PW-1:Q_FRAC];
    lres = $signed({{(PW-Q_FRAC-VAL_W+2){lhi_r[VAL_W-1]}}, lhi_r}) -
           (lneg_r ? -$signed({2'b00, tmag}) : $signed({2'b00, tmag}));
    if (lres > $signed((PW-Q_FRAC+2)'(32'sh7fff_ffff))) lsat = 32'sh7fff_ffff;
    else if (lres < -$signed((PW-Q_FRAC+2)'(33'h0_8000_0000))) lsat = 32'sh8000_0000;
    else lsat = lres[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!cmd.emit) begin
      case (cmd.op)
        OP_GADDR: g_addr_r <= IW'(px_r) + IW'(cmd.sel[0]) +
                              IW'(nx) * (IW'(py_r) + IW'(cmd.sel[1]));
        OP_GCAP: begin
          case (cmd.sel)
            2'd0:    z0_r <= gval;
            2'd1:    z1_r <= gval;
            2'd2:    z2_r <= gval;
            default: z3_r <= gval;
          endcase
        end
        OP_LPREP: begin
          lhi_r    <= lhi;
          ld_mag_r <= ld[DIFF_W-1] ? DIFF_W'(-ld) : DIFF_W'(ld);
          lf_mag_r <= lf[RATIO_W-1] ? RMAG_W'(-lf) : RMAG_W'(lf);
          lneg_r   <= ld[DIFF_W-1] ^ lf[RATIO_W-1];
          lsel_r   <= cmd.sel;
        end
        OP_MUL_LO: acc_r <= PW'(lf_mag_r * ld_mag_r[Q_FRAC-1:0]);
        OP_MUL_HI: pp_r  <= PW'(lf_mag_r * ld_mag_r[DIFF_W-1:Q_FRAC]);
        OP_LFIN: begin
          case (lsel_r)
            2'd0:    zmin_r <= lsat;
            2'd1:    zmax_r <= lsat;
            default: zres_r <= lsat;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (mode_r)
        MODE_UNKNOWN: begin
          out_z_r   <= '0;
          out_err_r <= 1'b1;
        end
        MODE_BILINEAR: begin
          out_z_r   <= zres_r;
          out_err_r <= 1'b0;
        end
        default: begin
          out_z_r   <= z0_r;
          out_err_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_z_value    = out_z_r;
  assign out_mode_error = out_err_r;

  assign stat.mode      = mode_r;
  assign stat.scan_done = (scan_i_r == maxn);
  assign stat.div_done  = (dcnt_r == '0);
  assign stat.out_busy  = out_valid_r && out_stall;

endmodule

// ===== rtl/gbi_controller.sv =====
// Controller: sequences one word at a time through scan, divide, grid read and line steps.
module gbi_controller (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [gbi_pkg::CMD_W-1:0] in_cmd,
  input  gbi_pkg::gbi_stat_t        stat,
  output gbi_pkg::gbi_cmd_t         cmd
);
  import gbi_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SCAN  = 5'd1;
  localparam logic [4:0] S_DRAIN = 5'd2;
  localparam logic [4:0] S_FIX   = 5'd3;
  localparam logic [4:0] S_RDLO  = 5'd4;
  localparam logic [4:0] S_RDHI  = 5'd5;
  localparam logic [4:0] S_CAPHI = 5'd6;
  localparam logic [4:0] S_NEAR  = 5'd7;
  localparam logic [4:0] S_DIVX  = 5'd8;
  localparam logic [4:0] S_WAITX = 5'd9;
  localparam logic [4:0] S_DIVY  = 5'd10;
  localparam logic [4:0] S_WAITY = 5'd11;
  localparam logic [4:0] S_GADDR = 5'd12;
  localparam logic [4:0] S_GWAIT = 5'd13;
  localparam logic [4:0] S_GCAP  = 5'd14;
  localparam logic [4:0] S_LPREP = 5'd15;
  localparam logic [4:0] S_MULLO = 5'd16;
  localparam logic [4:0] S_MULHI = 5'd17;
  localparam logic [4:0] S_LFIN  = 5'd18;
  localparam logic [4:0] S_EMIT  = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic [1:0] corner_r, corner_nxt, line_r, line_nxt;

  always_comb begin
    state_nxt  = state_r;
    corner_nxt = corner_r;
    line_nxt   = line_r;
    cmd.op     = OP_NONE;
    cmd.emit   = 1'b0;
    cmd.sel    = 2'd0;
    in_stall   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (in_cmd == CMD_EVAL) begin
            corner_nxt = 2'd0;
            line_nxt   = 2'd0;
            unique case (stat.mode)
              MODE_UNKNOWN: state_nxt = S_EMIT;
              MODE_CONST:   state_nxt = S_FIX;
              default:      state_nxt = S_SCAN;
            endcase
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_DRAIN;
        else cmd.op = OP_SCAN;
      end
      S_DRAIN: state_nxt = S_FIX;
      S_FIX: begin
        cmd.op    = OP_FIX;
        state_nxt = (stat.mode == MODE_CONST) ? S_GADDR : S_RDLO;
      end
      S_RDLO: begin
        cmd.op    = OP_RD_LO;
        state_nxt = S_RDHI;
      end
      S_RDHI: begin
        cmd.op    = OP_RD_HI;
        state_nxt = S_CAPHI;
      end
      S_CAPHI: begin
        cmd.op    = OP_CAP_HI;
        state_nxt = (stat.mode == MODE_NEAREST) ? S_NEAR : S_DIVX;
      end
      S_NEAR: begin
        cmd.op    = OP_NEAR_ADJ;
        state_nxt = S_GADDR;
      end
      S_DIVX: begin
        cmd.op    = OP_DIV_START;
        state_nxt = S_WAITX;
      end
      S_WAITX: begin
        if (stat.div_done) begin
          cmd.op    = OP_DIV_STORE;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.op    = OP_DIV_START;
        cmd.sel   = 2'd1;
        state_nxt = S_WAITY;
      end
      S_WAITY: begin
        if (stat.div_done) begin
          cmd.op    = OP_DIV_STORE;
          cmd.sel   = 2'd1;
          state_nxt = S_GADDR;
        end
      end
      S_GADDR: begin
        cmd.op    = OP_GADDR;
        cmd.sel   = corner_r;
        state_nxt = S_GWAIT;
      end
      S_GWAIT: state_nxt = S_GCAP;
      S_GCAP: begin
        cmd.op  = OP_GCAP;
        cmd.sel = corner_r;
        if (stat.mode != MODE_BILINEAR) begin
          state_nxt = S_EMIT;
        end else if (corner_r == 2'd3) begin
          state_nxt = S_LPREP;
        end else begin
          corner_nxt = corner_r + 2'd1;
          state_nxt  = S_GADDR;
        end
      end
      S_LPREP: begin
        cmd.op    = OP_LPREP;
        cmd.sel   = line_r;
        state_nxt = S_MULLO;
      end
      S_MULLO: begin
        cmd.op    = OP_MUL_LO;
        state_nxt = S_MULHI;
      end
      S_MULHI: begin
        cmd.op    = OP_MUL_HI;
        state_nxt = S_LFIN;
      end
      S_LFIN: begin
        cmd.op = OP_LFIN;
        if (line_r == 2'd2) begin
          state_nxt = S_EMIT;
        end else begin
          line_nxt  = line_r + 2'd1;
          state_nxt = S_LPREP;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_EMIT;
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      corner_r <= 2'd0;
      line_r   <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

// ===== rtl/grid_bilinear_interpolator_core.sv =====
// Top level of the grid bilinear interpolator: controller plus datapath.
//
// Input channel (in_valid/in_stall) carries one word per item: in_cmd selects
// an x axis write, a y axis write, a grid write or an evaluate. Writes produce no
// result word. An evaluate produces one result word on the output channel
// (out_valid/out_stall): out_z_value in Q16.16 and out_mode_error.
// The axis scan reads one axis entry per cycle per memory and covers
// N = max(x count, y count) entries; a bilinear evaluate then runs its two
// ratios, x then y, through the shared restoring divider.
// One item is processed at a time; in_stall is low only when the controller
// is idle, so a write word is taken every cycle between evaluates.
// A finished result sits in the output register; while out_stall holds it,
// the block still accepts and performs writes, and the next evaluate waits
// at its end for the register to free.
// Synchronous reset sets mode unknown and both counts to 2; the memories
// keep their contents and are undefined until written.
module grid_bilinear_interpolator_core #(
  parameter int MAX_AXIS_POINTS = gbi_pkg::MAX_AXIS_POINTS_DEF,
  parameter int GRID_CELLS      = gbi_pkg::GRID_CELLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [gbi_pkg::CMD_W-1:0]        in_cmd,
  input  logic [gbi_pkg::IDX_W-1:0]        in_entry_index,
  input  logic signed [gbi_pkg::VAL_W-1:0] in_entry_value,
  input  logic signed [gbi_pkg::VAL_W-1:0] in_query_x,
  input  logic signed [gbi_pkg::VAL_W-1:0] in_query_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [gbi_pkg::VAL_W-1:0] out_z_value,
  output logic                             out_mode_error,
  input  logic                             cfg_wr_en,
  input  logic [gbi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbi_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gbi_pkg::*;

  gbi_cmd_t  cmd;
  gbi_stat_t stat;

  gbi_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbi_datapath #(
    .MAX_AXIS_POINTS (MAX_AXIS_POINTS),
    .GRID_CELLS      (GRID_CELLS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_cmd         (in_cmd),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_query_x     (in_query_x),
    .in_query_y     (in_query_y),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_z_value    (out_z_value),
    .out_mode_error (out_mode_error)
  );

endmodule

// ===== tb/sv/grid_bilinear_interpolator_core_tb.sv =====
// Self-checking testbench of the grid bilinear interpolator core.
module grid_bilinear_interpolator_core_tb;
  import gbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAX = MAX_AXIS_POINTS_DEF;
  localparam int NGR = GRID_CELLS_DEF;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic signed [VAL_W-1:0] z;
    logic                    err;
  } z_word_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_cmd;
  logic [IDX_W-1:0]         in_entry_index;
  logic signed [VAL_W-1:0]  in_entry_value;
  logic signed [VAL_W-1:0]  in_query_x;
  logic signed [VAL_W-1:0]  in_query_y;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [VAL_W-1:0]  out_z_value;
  logic                     out_mode_error;
  logic                     cfg_wr_en;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  logic signed [VAL_W-1:0]  x_tab [NAX];
  logic signed [VAL_W-1:0]  y_tab [NAX];
  logic signed [VAL_W-1:0]  z_tab [NGR];
  logic [MODE_W-1:0]        mode_q;
  logic [COUNT_W-1:0]       xcnt_q;
  logic [COUNT_W-1:0]       ycnt_q;

  z_word_t z_pending[$];
  int  n_err;
  int  n_items;
  int  idle_cycles;
  int  hold_req;
  bit  tx_quiet;
  bit  rx_quiet;

  grid_bilinear_interpolator_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_entry_index(in_entry_index), .in_entry_value(in_entry_value),
    .in_query_x(in_query_x), .in_query_y(in_query_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_z_value(out_z_value), .out_mode_error(out_mode_error),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_count(logic [COUNT_W-1:0] c);
    if (c < 2) return 2;
    if (c > NAX) return NAX;
    return int'(c);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint axis_at(bit sel_y, int i);
    return sel_y ? longint'(y_tab[i]) : longint'(x_tab[i]);
  endfunction

  function automatic int leading_le(bit sel_y, int n, longint q);
    int p;
    p = -1;
    for (int i = 0; i < n; i++) begin
      if (axis_at(sel_y, i) > q) break;
      p = i;
    end
    return p;
  endfunction

  function automatic int clamp_cell(int p, int n);
    if (p < 0) p = 0;
    if (p > n - 2) p = n - 2;
    return p;
  endfunction

  function automatic int nearest_idx(bit sel_y, int n, longint q);
    int p;
    p = clamp_cell(leading_le(sel_y, n, q), n);
    if (2 * q > axis_at(sel_y, p) + axis_at(sel_y, p + 1)) p++;
    if (p > n - 1) p = n - 1;
    return p;
  endfunction

  function automatic int cell_idx(bit sel_y, int n, longint q);
    int p;
    if (q < axis_at(sel_y, 0)) p = -1;
    else if (q >= axis_at(sel_y, n - 1)) p = n;
    else p = leading_le(sel_y, n, q);
    return clamp_cell(p, n);
  endfunction

  function automatic longint grid_val(int xi, int yi, int nx);
    longint idx;
    idx = longint'(xi) + longint'(nx) * longint'(yi);
    if (idx >= NGR) return 0;
    return longint'(z_tab[idx]);
  endfunction

  function automatic longint frac_of(longint num, longint den);
    longint f;
    if (den == 0) return 0;
    f = (num * 65536) / den;
    if (f > 64'sd536870912) f = 64'sd536870912;
    if (f < -64'sd536870912) f = -64'sd536870912;
    return f;
  endfunction

  function automatic longint lerp(longint hi, longint lo, longint f);
    return sat32(hi - (f * (hi - lo)) / 65536);
  endfunction

  function automatic z_word_t eval_point(longint qx, longint qy);
    z_word_t r;
    int nx, ny, px, py;
    longint x0, x1, y0, y1, fx, fy, zlo, zhi;
    nx = eff_count(xcnt_q);
    ny = eff_count(ycnt_q);
    r.z = '0;
    r.err = 1'b0;
    case (mode_q)
      MODE_UNKNOWN: r.err = 1'b1;
      MODE_CONST: r.z = z_tab[0];
      MODE_NEAREST: begin
        px = nearest_idx(1'b0, nx, qx);
        py = nearest_idx(1'b1, ny, qy);
        r.z = VAL_W'(grid_val(px, py, nx));
      end
      default: begin
        px = cell_idx(1'b0, nx, qx);
        py = cell_idx(1'b1, ny, qy);
        x0 = axis_at(1'b0, px);
        x1 = axis_at(1'b0, px + 1);
        y0 = axis_at(1'b1, py);
        y1 = axis_at(1'b1, py + 1);
        fx = frac_of(x1 - qx, x1 - x0);
        fy = frac_of(y1 - qy, y1 - y0);
        zlo = lerp(grid_val(px + 1, py, nx), grid_val(px, py, nx), fx);
        zhi = lerp(grid_val(px + 1, py + 1, nx), grid_val(px, py + 1, nx), fx);
        r.z = VAL_W'(lerp(zhi, zlo, fy));
      end
    endcase
    return r;
  endfunction

  task automatic apply_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                            logic signed [VAL_W-1:0] val,
                            logic signed [VAL_W-1:0] qx, logic signed [VAL_W-1:0] qy);
    case (cmd)
      CMD_WR_X: if (idx < NAX) x_tab[idx] = val;
      CMD_WR_Y: if (idx < NAX) y_tab[idx] = val;
      CMD_WR_Z: if (idx < NGR) z_tab[idx] = val;
      default: z_pending = {z_pending, eval_point(longint'(qx), longint'(qy))};
    endcase
  endtask

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                           logic signed [VAL_W-1:0] val,
                           logic signed [VAL_W-1:0] qx, logic signed [VAL_W-1:0] qy);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_query_x     <= qx;
    in_query_y     <= qy;
    do @(posedge clk); while (in_stall);
    apply_word(cmd, idx, val, qx, qy);
    if (!(cmd inside {CMD_WR_X, CMD_WR_Y}) || idx < NAX) n_items++;
  endtask

  task automatic send_eval(logic signed [VAL_W-1:0] qx, logic signed [VAL_W-1:0] qy);
    send_word(CMD_EVAL, IDX_W'($urandom), $urandom, qx, qy);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (z_pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_MODE:   mode_q = data[MODE_W-1:0];
      CFG_XCOUNT: xcnt_q = data;
      CFG_YCOUNT: ycnt_q = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] xc,
                          logic [COUNT_W-1:0] yc);
    drain();
    write_reg(CFG_MODE, {5'($urandom), mode});
    write_reg(CFG_XCOUNT, xc);
    write_reg(CFG_YCOUNT, yc);
  endtask

  // shape 0 increasing, 1 increasing with repeats, 2 unordered
  task automatic load_axis(logic [CMD_W-1:0] cmd, int n, int shape);
    longint v;
    v = longint'($signed($urandom_range(0, 32'h07FF_FFFF))) - 64'sh0400_0000;
    for (int i = 0; i < n; i++) begin
      if (shape == 2) v = longint'($signed($urandom));
      send_word(cmd, IDX_W'(i), VAL_W'(v), $urandom, $urandom);
      if (shape != 2) v += (shape == 1 && $urandom_range(0, 2) == 0) ? 0
                           : $urandom_range(1, 32'h0010_0000);
    end
  endtask

  function automatic logic signed [VAL_W-1:0] grid_sample();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return VAL_W'(longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sh0100_0000);
  endfunction

  task automatic load_table(int shape);
    int nx, ny;
    nx = eff_count(xcnt_q);
    ny = eff_count(ycnt_q);
    load_axis(CMD_WR_X, nx, shape);
    load_axis(CMD_WR_Y, ny, (shape == 2) ? $urandom_range(0, 1) : shape);
    for (int i = 0; i < nx * ny; i++) send_word(CMD_WR_Z, IDX_W'(i), grid_sample(), $urandom, $urandom);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_query(bit sel_y);
    int n, i;
    longint a, b;
    n = eff_count(sel_y ? ycnt_q : xcnt_q);
    i = $urandom_range(0, n - 2);
    a = axis_at(sel_y, i);
    b = axis_at(sel_y, i + 1);
    case ($urandom_range(0, 6))
      0: return VAL_W'(a);
      1: return VAL_W'((a + b) / 2);
      2: return VAL_W'((a + b + 1) / 2);
      3: return $urandom;
      4: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      5: return VAL_W'(axis_at(sel_y, n - 1) + $urandom_range(0, 32'h00FF_FFFF));
      default: return VAL_W'(a + ((b - a) * $urandom_range(0, 1000)) / 1000);
    endcase
  endfunction

  task automatic test_unknown_mode();
    send_eval(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_eval(32'sh0000_0000, 32'shFFFF_FFFF);
  endtask

  task automatic test_constant();
    send_word(CMD_WR_X, 12'd0, 32'sh0000_0000, '0, '0);
    send_word(CMD_WR_X, 12'd1, 32'sh0001_0000, '0, '0);
    send_word(CMD_WR_Y, 12'd0, 32'sh8000_0000, '0, '0);
    send_word(CMD_WR_Y, 12'd1, 32'sh7FFF_FFFF, '0, '0);
    send_word(CMD_WR_Z, 12'd0, 32'sh7FFF_FFFF, '0, '0);
    send_word(CMD_WR_Z, 12'd1, 32'sh8000_0000, '0, '0);
    send_word(CMD_WR_Z, 12'd2, 32'sh0000_0001, '0, '0);
    send_word(CMD_WR_Z, 12'd3, 32'shFFFF_FFFF, '0, '0);
    set_regs(MODE_CONST, 7'd2, 7'd2);
    send_eval(32'sh1234_5678, 32'sh0);
  endtask

  task automatic test_nearest();
    set_regs(MODE_NEAREST, 7'd2, 7'd2);
    send_eval(32'sh0000_8000, 32'sh0);
    send_eval(32'sh0000_8001, 32'sh7FFF_FFFF);
    send_eval(32'sh8000_0000, 32'sh8000_0000);
  endtask

  task automatic test_bilinear();
    set_regs(MODE_BILINEAR, 7'd2, 7'd2);
    send_eval(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_eval(32'sh8000_0000, 32'sh0);
    send_eval(32'sh0000_4000, 32'sh0000_0001);
    // zero-width x interval, then a new first y axis entry
    send_word(CMD_WR_X, 12'd1, 32'sh0000_0000, '0, '0);
    send_eval(32'sh0000_0000, 32'sh0000_1000);
    send_word(CMD_WR_Y, 12'd0, 32'sh0004_0000, '0, '0);
    send_eval(32'sh0000_0001, 32'sh0000_2000);
    // axis writes past the table end are dropped
    send_word(CMD_WR_X, 12'hFFF, 32'sh7FFF_FFFF, '0, '0);
    send_word(CMD_WR_Y, 12'd64, 32'sh8000_0000, '0, '0);
    send_eval(32'sh0000_0000, 32'sh0000_3000);
    // counts below range act as two
    set_regs(MODE_BILINEAR, 7'd0, 7'd1);
    send_eval(32'sh0000_0000, 32'sh0000_1000);
  endtask

  task automatic run_phase(int n_words);
    int r, nx, ny;
    for (int k = 0; k < n_words; k++) begin
      nx = eff_count(xcnt_q);
      ny = eff_count(ycnt_q);
      r = $urandom_range(0, 19);
      if (r < 15) send_eval(pick_query(1'b0), pick_query(1'b1));
      else if (r == 15) send_word(CMD_WR_X, IDX_W'($urandom_range(0, nx - 1)), $urandom, '0, '0);
      else if (r == 16) send_word(CMD_WR_Y, IDX_W'($urandom_range(0, ny - 1)), $urandom, '0, '0);
      else if (r == 17) send_word(CMD_WR_Z, IDX_W'($urandom_range(0, nx * ny - 1)),
                                  grid_sample(), '0, '0);
      else if (r == 18) send_word(CMD_WR_Z, IDX_W'($urandom), $urandom, $urandom, $urandom);
      else send_word(logic'($urandom_range(0, 1)) ? CMD_WR_Y : CMD_WR_X,
                     IDX_W'($urandom_range(NAX, 4095)), $urandom, '0, '0);
    end
  endtask

  task automatic test_random_tables();
    logic [MODE_W-1:0] mode;
    logic [COUNT_W-1:0] xc, yc;
    while (n_items < 400) begin
      mode = ($urandom_range(0, 9) < 2) ? MODE_W'($urandom_range(0, 1))
                                        : MODE_W'($urandom_range(2, 3));
      xc = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom) : COUNT_W'($urandom_range(2, 8));
      yc = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom) : COUNT_W'($urandom_range(2, 8));
      if (eff_count(xc) * eff_count(yc) > 256) yc = COUNT_W'($urandom_range(2, 3));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      set_regs(mode, xc, yc);
      load_table($urandom_range(0, 5) / 2);
      run_phase($urandom_range(20, 40));
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_full_grid();
    tx_quiet = 1'b1;
    set_regs(MODE_BILINEAR, 7'd127, 7'd2);
    load_table(0);
    tx_quiet = 1'b0;
    run_phase(12);
    set_regs(MODE_NEAREST, 7'd64, 7'd1);
    run_phase(12);
  endtask

  task automatic test_backpressure();
    set_regs(MODE_BILINEAR, 7'd3, 7'd2);
    load_table(0);
    drain();
    tx_quiet = 1'b1;
    hold_req = 400;
    for (int k = 0; k < 10; k++) send_eval(pick_query(1'b0), pick_query(1'b1));
    run_phase(10);
    tx_quiet = 1'b0;
    drain();
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        int n;
        n = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      begin
        int n;
        n = rx_quiet ? 0 : $urandom_range(0, 14);
        out_stall <= (n > 0);
        if (n > 0) begin
          repeat (n) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (!(out_valid && !out_stall) && hold_req == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (z_pending.size() == 0) begin
        $error("result word with nothing pending: z_value %0h", out_z_value);
        n_err++;
      end else begin
        z_word_t e;
        e = z_pending.pop_front();
        if (out_z_value !== e.z) begin
          $error("z_value expected %0h actual %0h", e.z, out_z_value);
          n_err++;
        end
        if (out_mode_error !== e.err) begin
          $error("mode_error expected %0b actual %0b", e.err, out_mode_error);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_WR_X;
    in_entry_index = '0;
    in_entry_value = '0;
    in_query_x = '0;
    in_query_y = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    n_err = 0;
    n_items = 0;
    idle_cycles = 0;
    hold_req = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    mode_q = MODE_UNKNOWN;
    xcnt_q = 7'd2;
    ycnt_q = 7'd2;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_unknown_mode();
    test_constant();
    test_nearest();
    test_bilinear();
    test_random_tables();
    test_full_grid();
    test_backpressure();
    drain();
    repeat (200) @(posedge clk);
    if (n_err == 0 && z_pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
